FILE: hdl/first_fit_heap_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// first fit heap allocator assertion macros
// concurrent assertion helpers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define FFA_ASSERT_IMPL(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define FFA_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define FFA_ASSERT_IMPL(lbl, clk, rst, a, b)
`define FFA_ASSERT_NEXT(lbl, clk, rst, a, b)
`endif
`endif

FILE: hdl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// types, codes and defaults shared by the first fit heap allocator
// ----------------------------------------------------------------------------
package ffa_pkg;

   localparam int PAGE_BYTES_DEF   = 4096;
   localparam int HEADER_BYTES_DEF = 12;
   localparam int MAX_PAGES_DEF    = 16;
   localparam int MAX_BLOCKS_DEF   = 64;
   localparam int INIT_PAGES_DEF   = 4;
   localparam int SPLIT_SLACK      = 16;
   localparam logic [4:0] PAGE_LIMIT_RESET = 5'd16;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_ZERO    = 2'd1;
   localparam logic [1:0] STATUS_OOM     = 2'd2;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd3;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic        op;
      logic [15:0] req_size;
      logic [15:0] free_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] data_offset;
      logic [16:0] used_bytes;
      logic [16:0] free_bytes;
   } rsp_type;

   typedef struct packed {
      logic [15:0] start;
      logic [15:0] bytes;
      logic        is_free;
   } entry_type;

   typedef enum logic [4:0] {
      ST_INIT, ST_IDLE, ST_A_RD, ST_A_CHK, ST_A_GROW, ST_S_RD, ST_S_WR, ST_S_FIX,
      ST_F_RD, ST_F_CHK, ST_M_RD0, ST_M_LD, ST_M_RD, ST_M_CHK, ST_U_START,
      ST_U_RD, ST_U_ACC, ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      ACT_NONE, ACT_INIT_WR, ACT_ACCEPT, ACT_RD_IDX, ACT_A_MISS, ACT_A_TAKE,
      ACT_A_SPLIT, ACT_S_RD, ACT_S_WR, ACT_S_INS, ACT_S_FIX, ACT_GROW, ACT_OOM,
      ACT_F_MISS, ACT_F_HIT, ACT_UNKNOWN, ACT_M_LOAD, ACT_M_STEP, ACT_M_END,
      ACT_SUM_START, ACT_SUM_ACC, ACT_LOAD_RSP
   } action_type;

   typedef struct packed {
      action_type action;
   } cmd_type;

   typedef struct packed {
      logic init_last;
      logic in_free;
      logic zero_size;
      logic idx_end;
      logic fit;
      logic split;
      logic grow_ok;
      logic pos_at_ins;
      logic match;
      logic rsp_free;
   } stat_type;

endpackage

FILE: hdl/ffa_ram.sv
// ----------------------------------------------------------------------------
// ffa_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module ffa_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 64
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                   wr_data,
   input  logic                               rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                   rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

FILE: hdl/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// ffa_ctrl
// sequencer for search, split, grow, free, merge and totals passes
// ----------------------------------------------------------------------------
module ffa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ffa_pkg::stat_type stat,
   output ffa_pkg::cmd_type  cmd
);

   ffa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffa_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.action = ffa_pkg::ACT_NONE;
      req_ready  = 1'b0;
      unique case (state_ff)
         ffa_pkg::ST_INIT: begin
            cmd.action = ffa_pkg::ACT_INIT_WR;
            if (stat.init_last) state_in = ffa_pkg::ST_IDLE;
         end
         ffa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.action = ffa_pkg::ACT_ACCEPT;
               if (stat.in_free) begin
                  state_in = ffa_pkg::ST_F_RD;
               end else if (stat.zero_size) begin
                  state_in = ffa_pkg::ST_U_START;
               end else begin
                  state_in = ffa_pkg::ST_A_RD;
               end
            end
         end
         ffa_pkg::ST_A_RD: begin
            if (stat.idx_end) begin
               state_in = ffa_pkg::ST_A_GROW;
            end else begin
               cmd.action = ffa_pkg::ACT_RD_IDX;
               state_in   = ffa_pkg::ST_A_CHK;
            end
         end
         ffa_pkg::ST_A_CHK: begin
            if (stat.fit && stat.split) begin
               cmd.action = ffa_pkg::ACT_A_SPLIT;
               state_in   = ffa_pkg::ST_S_RD;
            end else if (stat.fit) begin
               cmd.action = ffa_pkg::ACT_A_TAKE;
               state_in   = ffa_pkg::ST_U_START;
            end else begin
               cmd.action = ffa_pkg::ACT_A_MISS;
               state_in   = ffa_pkg::ST_A_RD;
            end
         end
         ffa_pkg::ST_A_GROW: begin
            if (stat.grow_ok) begin
               cmd.action = ffa_pkg::ACT_GROW;
               state_in   = ffa_pkg::ST_A_RD;
            end else begin
               cmd.action = ffa_pkg::ACT_OOM;
               state_in   = ffa_pkg::ST_U_START;
            end
         end
         ffa_pkg::ST_S_RD: begin
            if (stat.pos_at_ins) begin
               cmd.action = ffa_pkg::ACT_S_INS;
               state_in   = ffa_pkg::ST_S_FIX;
            end else begin
               cmd.action = ffa_pkg::ACT_S_RD;
               state_in   = ffa_pkg::ST_S_WR;
            end
         end
         ffa_pkg::ST_S_WR: begin
            cmd.action = ffa_pkg::ACT_S_WR;
            state_in   = ffa_pkg::ST_S_RD;
         end
         ffa_pkg::ST_S_FIX: begin
            cmd.action = ffa_pkg::ACT_S_FIX;
            state_in   = ffa_pkg::ST_U_START;
         end
         ffa_pkg::ST_F_RD: begin
            if (stat.idx_end) begin
               cmd.action = ffa_pkg::ACT_UNKNOWN;
               state_in   = ffa_pkg::ST_U_START;
            end else begin
               cmd.action = ffa_pkg::ACT_RD_IDX;
               state_in   = ffa_pkg::ST_F_CHK;
            end
         end
         ffa_pkg::ST_F_CHK: begin
            if (stat.match) begin
               cmd.action = ffa_pkg::ACT_F_HIT;
               state_in   = ffa_pkg::ST_M_RD0;
            end else begin
               cmd.action = ffa_pkg::ACT_F_MISS;
               state_in   = ffa_pkg::ST_F_RD;
            end
         end
         ffa_pkg::ST_M_RD0: begin
            cmd.action = ffa_pkg::ACT_RD_IDX;
            state_in   = ffa_pkg::ST_M_LD;
         end
         ffa_pkg::ST_M_LD: begin
            cmd.action = ffa_pkg::ACT_M_LOAD;
            state_in   = ffa_pkg::ST_M_RD;
         end
         ffa_pkg::ST_M_RD: begin
            if (stat.idx_end) begin
               cmd.action = ffa_pkg::ACT_M_END;
               state_in   = ffa_pkg::ST_U_START;
            end else begin
               cmd.action = ffa_pkg::ACT_RD_IDX;
               state_in   = ffa_pkg::ST_M_CHK;
            end
         end
         ffa_pkg::ST_M_CHK: begin
            cmd.action = ffa_pkg::ACT_M_STEP;
            state_in   = ffa_pkg::ST_M_RD;
         end
         ffa_pkg::ST_U_START: begin
            cmd.action = ffa_pkg::ACT_SUM_START;
            state_in   = ffa_pkg::ST_U_RD;
         end
         ffa_pkg::ST_U_RD: begin
            if (stat.idx_end) begin
               state_in = ffa_pkg::ST_DONE;
            end else begin
               cmd.action = ffa_pkg::ACT_RD_IDX;
               state_in   = ffa_pkg::ST_U_ACC;
            end
         end
         ffa_pkg::ST_U_ACC: begin
            cmd.action = ffa_pkg::ACT_SUM_ACC;
            state_in   = ffa_pkg::ST_U_RD;
         end
         ffa_pkg::ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.action = ffa_pkg::ACT_LOAD_RSP;
               state_in   = ffa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ffa_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/ffa_datapath.sv
// ----------------------------------------------------------------------------
// ffa_datapath
// block table ram, counters, working registers and result register
// ----------------------------------------------------------------------------
module ffa_datapath #(
   parameter int PAGE_BYTES   = ffa_pkg::PAGE_BYTES_DEF,
   parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
   parameter int MAX_PAGES    = ffa_pkg::MAX_PAGES_DEF,
   parameter int MAX_BLOCKS   = ffa_pkg::MAX_BLOCKS_DEF,
   parameter int INIT_PAGES   = ffa_pkg::INIT_PAGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  ffa_pkg::req_type  req_data,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output ffa_pkg::rsp_type  rsp_data,
   input  logic              csr_wr_en,
   input  logic [4:0]        csr_wr_data,
   input  ffa_pkg::cmd_type  cmd,
   output ffa_pkg::stat_type stat
);

   localparam int N0 = (INIT_PAGES < MAX_PAGES) ?
                       ((INIT_PAGES < MAX_BLOCKS) ? INIT_PAGES : MAX_BLOCKS) :
                       ((MAX_PAGES < MAX_BLOCKS) ? MAX_PAGES : MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int PW = $clog2(MAX_PAGES + 1);
   localparam int EW = $bits(ffa_pkg::entry_type);
   localparam logic [15:0] HDR16  = 16'(HEADER_BYTES);
   localparam logic [15:0] PAGE16 = 16'(PAGE_BYTES);
   localparam logic [15:0] DATA16 = 16'(PAGE_BYTES - HEADER_BYTES);
   localparam logic [4:0]  MAXP5  = 5'(MAX_PAGES);
   localparam logic [CW-1:0] MAXB = CW'(MAX_BLOCKS);
   localparam logic [CW-1:0] N0C  = CW'(N0);
   localparam logic [17:0] SPLIT_ADD = 18'(HEADER_BYTES + ffa_pkg::SPLIT_SLACK);

   logic [CW-1:0] cnt_ff, cnt_in, idx_ff, idx_in, pos_ff, pos_in;
   logic [PW-1:0] pages_ff, pages_in;
   logic [4:0]    limit_ff, limit_in;
   logic          rsp_valid_ff, rsp_valid_in;
   ffa_pkg::rsp_type   rsp_ff, rsp_in;
   ffa_pkg::entry_type cur_ff, cur_in;
   logic [16:0]   size_ff, size_in;
   logic [15:0]   off_ff, off_in, dofs_ff, dofs_in;
   logic [1:0]    st_ff, st_in;
   logic [16:0]   used_ff, used_in, freeb_ff, freeb_in;

   logic               wr_en, rd_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   ffa_pkg::entry_type wr_ent, rd_ent;
   logic [EW-1:0]      rd_raw;
   logic [4:0]         lim5;

   ffa_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ent),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_ent = ffa_pkg::entry_type'(rd_raw);
   assign lim5   = (limit_ff > MAXP5) ? MAXP5 : limit_ff;

   always_comb begin
      stat.init_last  = (idx_ff == N0C - CW'(1));
      stat.in_free    = (req_data.op == ffa_pkg::OP_FREE);
      stat.zero_size  = (req_data.op == ffa_pkg::OP_ALLOC) && (req_data.req_size == 16'd0);
      stat.idx_end    = (idx_ff == cnt_ff);
      stat.fit        = rd_ent.is_free && ({1'b0, rd_ent.bytes} >= size_ff);
      stat.split      = ({2'b00, rd_ent.bytes} > ({1'b0, size_ff} + SPLIT_ADD)) &&
                        (cnt_ff < MAXB);
      stat.grow_ok    = (5'(pages_ff) < lim5) && (cnt_ff < MAXB);
      stat.pos_at_ins = (pos_ff == idx_ff + CW'(1));
      stat.match      = (({1'b0, rd_ent.start} + {1'b0, HDR16}) == {1'b0, off_ff});
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      pos_in   = pos_ff;
      pages_in = pages_ff;
      limit_in = csr_wr_en ? csr_wr_data : limit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in   = rsp_ff;
      cur_in   = cur_ff;
      size_in  = size_ff;
      off_in   = off_ff;
      dofs_in  = dofs_ff;
      st_in    = st_ff;
      used_in  = used_ff;
      freeb_in = freeb_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff[AW-1:0];
      wr_ent   = rd_ent;
      rd_en    = 1'b0;
      rd_addr  = idx_ff[AW-1:0];
      unique case (cmd.action)
         ffa_pkg::ACT_INIT_WR: begin
            wr_en  = 1'b1;
            wr_ent = '{start: 16'(idx_ff) * PAGE16, bytes: DATA16, is_free: 1'b1};
            idx_in = idx_ff + CW'(1);
         end
         ffa_pkg::ACT_ACCEPT: begin
            size_in = ({1'b0, req_data.req_size} + 17'd3) & ~17'd3;
            off_in  = req_data.free_offset;
            dofs_in = 16'd0;
            st_in   = (req_data.req_size == 16'd0 && req_data.op == ffa_pkg::OP_ALLOC) ?
                      ffa_pkg::STATUS_ZERO : ffa_pkg::STATUS_OK;
            idx_in  = (req_data.req_size == 16'd0 && req_data.op == ffa_pkg::OP_ALLOC) ?
                      cnt_ff : CW'(0);
         end
         ffa_pkg::ACT_RD_IDX: begin
            rd_en = 1'b1;
         end
         ffa_pkg::ACT_A_MISS, ffa_pkg::ACT_F_MISS: begin
            idx_in = idx_ff + CW'(1);
         end
         ffa_pkg::ACT_A_TAKE: begin
            wr_en   = 1'b1;
            wr_ent  = '{start: rd_ent.start, bytes: rd_ent.bytes, is_free: 1'b0};
            dofs_in = rd_ent.start + HDR16;
         end
         ffa_pkg::ACT_A_SPLIT: begin
            cur_in  = rd_ent;
            dofs_in = rd_ent.start + HDR16;
            pos_in  = cnt_ff;
         end
         ffa_pkg::ACT_S_RD: begin
            rd_en   = 1'b1;
            rd_addr = AW'(pos_ff - CW'(1));
         end
         ffa_pkg::ACT_S_WR: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff[AW-1:0];
            pos_in  = pos_ff - CW'(1);
         end
         ffa_pkg::ACT_S_INS: begin
            wr_en   = 1'b1;
            wr_addr = AW'(idx_ff + CW'(1));
            wr_ent  = '{start: cur_ff.start + HDR16 + size_ff[15:0],
                        bytes: cur_ff.bytes - size_ff[15:0] - HDR16, is_free: 1'b1};
            cnt_in  = cnt_ff + CW'(1);
         end
         ffa_pkg::ACT_S_FIX: begin
            wr_en  = 1'b1;
            wr_ent = '{start: cur_ff.start, bytes: size_ff[15:0], is_free: 1'b0};
         end
         ffa_pkg::ACT_GROW: begin
            wr_en    = 1'b1;
            wr_addr  = cnt_ff[AW-1:0];
            wr_ent   = '{start: 16'(pages_ff) * PAGE16, bytes: DATA16, is_free: 1'b1};
            cnt_in   = cnt_ff + CW'(1);
            pages_in = pages_ff + PW'(1);
         end
         ffa_pkg::ACT_OOM: begin
            st_in = ffa_pkg::STATUS_OOM;
         end
         ffa_pkg::ACT_UNKNOWN: begin
            st_in = ffa_pkg::STATUS_UNKNOWN;
         end
         ffa_pkg::ACT_F_HIT: begin
            wr_en  = 1'b1;
            wr_ent = '{start: rd_ent.start, bytes: rd_ent.bytes, is_free: 1'b1};
            idx_in = CW'(0);
            pos_in = CW'(0);
         end
         ffa_pkg::ACT_M_LOAD: begin
            cur_in = rd_ent;
            idx_in = idx_ff + CW'(1);
         end
         ffa_pkg::ACT_M_STEP: begin
            idx_in = idx_ff + CW'(1);
            if (cur_ff.is_free && rd_ent.is_free) begin
               cur_in.bytes = cur_ff.bytes + HDR16 + rd_ent.bytes;
            end else begin
               wr_en   = 1'b1;
               wr_addr = pos_ff[AW-1:0];
               wr_ent  = cur_ff;
               pos_in  = pos_ff + CW'(1);
               cur_in  = rd_ent;
            end
         end
         ffa_pkg::ACT_M_END: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff[AW-1:0];
            wr_ent  = cur_ff;
            cnt_in  = pos_ff + CW'(1);
         end
         ffa_pkg::ACT_SUM_START: begin
            idx_in   = CW'(0);
            used_in  = 17'd0;
            freeb_in = 17'd0;
         end
         ffa_pkg::ACT_SUM_ACC: begin
            idx_in = idx_ff + CW'(1);
            if (rd_ent.is_free) begin
               freeb_in = freeb_ff + {1'b0, rd_ent.bytes};
            end else begin
               used_in = used_ff + {1'b0, rd_ent.bytes};
            end
         end
         ffa_pkg::ACT_LOAD_RSP: begin
            rsp_valid_in = 1'b1;
            rsp_in = '{status: st_ff,
                       data_offset: (st_ff == ffa_pkg::STATUS_OK) ? dofs_ff : 16'd0,
                       used_bytes: used_ff, free_bytes: freeb_ff};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= N0C;
         idx_ff       <= CW'(0);
         pages_ff     <= PW'(N0);
         limit_ff     <= ffa_pkg::PAGE_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         pages_ff     <= pages_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      rsp_ff   <= rsp_in;
      cur_ff   <= cur_in;
      size_ff  <= size_in;
      off_ff   <= off_in;
      dofs_ff  <= dofs_in;
      st_ff    <= st_in;
      used_ff  <= used_in;
      freeb_ff <= freeb_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hdl/first_fit_heap_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// first fit allocator over a page arena with split, growth and coalescing
// ----------------------------------------------------------------------------
// One request is handled at a time. The block table sits in a single-port-read
// ram, so every pass walks it one entry at a time: the allocate search over
// the entries visited, a shift of the entries above a split block, the free
// search plus a full merge walk, and a final totals walk over all blocks. A
// zero size request only walks the totals. An allocate with no fit appends a
// page, if the page limit and table allow, and searches on. A result that is
// not taken holds the block in its last state. After reset the initial pages,
// INIT_PAGES capped at MAX_PAGES and MAX_BLOCKS, are written into the table
// before the first request is taken. The result is held in an output register
// while the next request is taken.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_unit_macros.svh"

module first_fit_heap_allocator_unit #(
   parameter int PAGE_BYTES   = ffa_pkg::PAGE_BYTES_DEF,
   parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
   parameter int MAX_PAGES    = ffa_pkg::MAX_PAGES_DEF,
   parameter int MAX_BLOCKS   = ffa_pkg::MAX_BLOCKS_DEF,
   parameter int INIT_PAGES   = ffa_pkg::INIT_PAGES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ffa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ffa_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [4:0]       csr_wr_data
);

   ffa_pkg::cmd_type  cmd;
   ffa_pkg::stat_type stat;

   ffa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ffa_datapath #(
      .PAGE_BYTES   (PAGE_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .MAX_PAGES    (MAX_PAGES),
      .MAX_BLOCKS   (MAX_BLOCKS),
      .INIT_PAGES   (INIT_PAGES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat)
   );

   `FFA_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)
   `FFA_ASSERT_IMPL(a_load_when_free, clock, reset, cmd.action == ffa_pkg::ACT_LOAD_RSP,
      !rsp_valid || rsp_ready)
   `FFA_ASSERT_IMPL(a_offset_zero_on_error, clock, reset,
      rsp_valid && rsp_data.status != ffa_pkg::STATUS_OK, rsp_data.data_offset == 16'd0)

endmodule
